/* hw/rtl/tfc_pkg.sv */
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared constants, types and helpers for the thermal false-color pixel writer.
// ----------------------------------------------------------------------------
package tfc_pkg;

  // Field widths fixed by the stream formats
  localparam int WORD_W     = 10;
  localparam int TEMP_W     = 16;
  localparam int CFG_W      = 14;
  localparam int ZOOM_W     = 4;
  localparam int COLOR_W    = 8;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // Frame index: word index plus the second-half offset
  localparam int IDX_W       = 11;
  localparam int HALF_OFFSET = 529;

  // Limits held in tenths of a kelvin, differences and divider operands
  localparam int LIM_K_W       = 18;
  localparam int DIFF_W        = 19;
  localparam int P_W           = 18;
  localparam int N_W           = P_W + COLOR_W;
  localparam int KELVIN_OFFSET = 273;

  localparam logic [COLOR_W-1:0] FULL_SCALE = 8'd255;

  // Queue between classifier and write replicator
  localparam int QUEUE_DEPTH = 4;

  // Default geometry
  localparam int MAX_ZOOM_DEF       = 8;
  localparam int SENSOR_COLUMNS_DEF = 32;
  localparam int SENSOR_ROWS_DEF    = 31;

  // Register reset values
  localparam int LOW_LIMIT_RESET  = 25;
  localparam int HIGH_LIMIT_RESET = 45;
  localparam logic [ZOOM_W-1:0] ZOOM_RESET = 4'd1;

  localparam logic signed [LIM_K_W-1:0] LO_K_RESET =
    LIM_K_W'((LOW_LIMIT_RESET + KELVIN_OFFSET) * 10);
  localparam logic signed [LIM_K_W-1:0] HI_K_RESET =
    LIM_K_W'((HIGH_LIMIT_RESET + KELVIN_OFFSET) * 10);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LIMIT  = 2'd0,
    CFG_HIGH_LIMIT = 2'd1,
    CFG_ZOOM       = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } colour_t;

  // Convert whole degrees Celsius to tenths of a kelvin
  function automatic logic signed [LIM_K_W-1:0] to_deci_kelvin(
    input logic signed [CFG_W-1:0] celsius
  );
    logic signed [LIM_K_W-1:0] kel;
    kel = LIM_K_W'(celsius) + LIM_K_W'(KELVIN_OFFSET);
    return (kel <<< 3) + (kel <<< 1);
  endfunction

endpackage

/* hw/rtl/tfc_div.sv */
// ----------------------------------------------------------------------------
// tfc_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module tfc_div #(
  parameter int N_W   = 26,
  parameter int D_W   = 18,
  parameter int Q_W   = 8,
  parameter int TAG_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [N_W-1:0]   in_num,
  input  logic [D_W-1:0]   in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_quo,
  output logic             out_rem_nz,
  output logic [TAG_W-1:0] out_tag
);

  // Stage registers
  logic             vld_r [Q_W];
  logic [N_W-1:0]   rem_r [Q_W];
  logic [D_W-1:0]   den_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];
  logic [TAG_W-1:0] tag_r [Q_W];

  // Stage inputs
  logic             vld_in [Q_W];
  logic [N_W-1:0]   rem_in [Q_W];
  logic [D_W-1:0]   den_in [Q_W];
  logic [Q_W-1:0]   quo_in [Q_W];
  logic [TAG_W-1:0] tag_in [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int K = Q_W - 1 - i;

    logic [N_W-1:0] shifted;
    logic           ge;

    // Chain each stage to the one before it
    if (i == 0) begin : g_first
      assign vld_in[i] = in_valid;
      assign rem_in[i] = in_num;
      assign den_in[i] = in_den;
      assign quo_in[i] = '0;
      assign tag_in[i] = in_tag;
    end else begin : g_next
      assign vld_in[i] = vld_r[i-1];
      assign rem_in[i] = rem_r[i-1];
      assign den_in[i] = den_r[i-1];
      assign quo_in[i] = quo_r[i-1];
      assign tag_in[i] = tag_r[i-1];
    end

    // Trial subtract of the shifted divisor
    assign shifted = N_W'(den_in[i]) << K;
    assign ge      = (rem_in[i] >= shifted);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? (rem_in[i] - shifted) : rem_in[i];
        den_r[i] <= den_in[i];
        quo_r[i] <= {quo_in[i][Q_W-2:0], ge};
        tag_r[i] <= tag_in[i];
      end
    end
  end

  assign out_valid  = vld_r[Q_W-1];
  assign out_quo    = quo_r[Q_W-1];
  assign out_rem_nz = (rem_r[Q_W-1] != '0);
  assign out_tag    = tag_r[Q_W-1];

endmodule

/* hw/rtl/tfc_front.sv */
// ----------------------------------------------------------------------------
// tfc_front
// Accept sensor words, place them in the frame and map temperature to color.
// ----------------------------------------------------------------------------
module tfc_front #(
  parameter int SENSOR_COLUMNS = 32,
  parameter int SENSOR_ROWS    = 31,
  parameter int COL_W          = 5,
  parameter int ROW_W          = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                second_packet,
  input  logic [tfc_pkg::WORD_W-1:0]          word_index,
  input  logic [tfc_pkg::TEMP_W-1:0]          temperature,
  input  logic signed [tfc_pkg::LIM_K_W-1:0]  lo_limit_k,
  input  logic signed [tfc_pkg::LIM_K_W-1:0]  hi_limit_k,
  input  logic                                zoom_off,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [COL_W-1:0]                    out_col,
  output logic [ROW_W-1:0]                    out_row,
  output tfc_pkg::colour_t                    out_colour
);
  import tfc_pkg::*;

  // Reciprocal for the row split: exact floor for every IDX_W-bit index
  localparam int SHIFT   = IDX_W + $clog2(SENSOR_COLUMNS);
  localparam int RECIP   = (2**SHIFT + SENSOR_COLUMNS - 1) / SENSOR_COLUMNS;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = IDX_W + RECIP_W;
  localparam int TAG_W   = 4 + COL_W + ROW_W;

  logic adv;

  logic                     s1_valid;
  logic [IDX_W-1:0]         s1_idx;
  logic [TEMP_W-1:0]        s1_temp;

  logic                     s2_valid;
  logic [IDX_W-1:0]         s2_idx;
  logic [IDX_W-1:0]         s2_row;
  logic                     s2_black;
  logic                     s2_white;
  logic                     s2_lower;
  logic signed [DIFF_W-1:0] s2_tl;
  logic signed [DIFF_W-1:0] s2_th;
  logic signed [DIFF_W-1:0] s2_d;

  logic                     s3_valid;
  logic                     s3_keep;
  logic [COL_W-1:0]         s3_col;
  logic [ROW_W-1:0]         s3_row;
  logic                     s3_black;
  logic                     s3_white;
  logic                     s3_lower;
  logic [P_W-1:0]           s3_p;
  logic [P_W-1:0]           s3_d;

  logic                     s4_valid;
  logic [N_W-1:0]           s4_num;
  logic [P_W-1:0]           s4_d;
  logic [TAG_W-1:0]         s4_tag;

  logic [IDX_W-1:0]         idx;
  logic [PROD_W-1:0]        row_prod;
  logic signed [DIFF_W-1:0] t_x;
  logic signed [DIFF_W-1:0] lo_x;
  logic signed [DIFF_W-1:0] hi_x;
  logic signed [DIFF_W-1:0] tl;
  logic signed [DIFF_W-1:0] th;
  logic signed [DIFF_W-1:0] dd;
  logic [IDX_W-1:0]         row_base;
  logic [COL_W-1:0]         raw;
  logic [COL_W-1:0]         col;
  logic [P_W-1:0]           p;

  logic                     dv_valid;
  logic [COLOR_W-1:0]       dv_quo;
  logic                     dv_rem_nz;
  logic [TAG_W-1:0]         dv_tag;
  logic                     dv_keep;
  logic                     dv_black;
  logic                     dv_white;
  logic                     dv_lower;
  logic [COLOR_W-1:0]       ramp_down;
  colour_t                  colour;

  // Whole pipeline moves unless the output holds an untaken item
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: frame index
  assign idx = IDX_W'(word_index) + (second_packet ? IDX_W'(HALF_OFFSET) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx  <= idx;
      s1_temp <= temperature;
    end
  end

  // Stage 2: row by reciprocal, temperature against the limits
  assign row_prod = PROD_W'(s1_idx) * PROD_W'(RECIP);
  assign t_x      = DIFF_W'(s1_temp);
  assign lo_x     = DIFF_W'(lo_limit_k);
  assign hi_x     = DIFF_W'(hi_limit_k);
  assign tl       = t_x - lo_x;
  assign th       = hi_x - t_x;
  assign dd       = hi_x - lo_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_idx   <= s1_idx;
      s2_row   <= IDX_W'(row_prod >> SHIFT);
      s2_black <= tl[DIFF_W-1];
      s2_white <= th[DIFF_W-1] || dd[DIFF_W-1] || (dd == '0);
      s2_lower <= (tl < th);
      s2_tl    <= tl;
      s2_th    <= th;
      s2_d     <= dd;
    end
  end

  // Stage 3: column reorder, frame check, ramp position
  assign row_base = IDX_W'(s2_row * IDX_W'(SENSOR_COLUMNS));
  assign raw      = COL_W'(s2_idx - row_base);
  assign col      = COL_W'(raw >> 1) + (raw[0] ? COL_W'(SENSOR_COLUMNS / 2) : '0);
  assign p        = s2_lower ? P_W'(s2_tl <<< 1) : P_W'(s2_tl - s2_th);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_keep  <= (s2_row < IDX_W'(SENSOR_ROWS)) && !zoom_off;
      s3_col   <= col;
      s3_row   <= ROW_W'(s2_row);
      s3_black <= s2_black;
      s3_white <= s2_white;
      s3_lower <= s2_lower;
      s3_p     <= p;
      s3_d     <= P_W'(s2_d);
    end
  end

  // Stage 4: scale the ramp position by full scale
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_num <= (N_W'(s3_p) << COLOR_W) - N_W'(s3_p);
      s4_d   <= s3_d;
      s4_tag <= {s3_keep, s3_black, s3_white, s3_lower, s3_col, s3_row};
    end
  end

  // Ramp fraction: floor of scaled position over the span
  tfc_div #(
    .N_W   (N_W),
    .D_W   (P_W),
    .Q_W   (COLOR_W),
    .TAG_W (TAG_W)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .in_valid   (s4_valid),
    .in_num     (s4_num),
    .in_den     (s4_d),
    .in_tag     (s4_tag),
    .out_valid  (dv_valid),
    .out_quo    (dv_quo),
    .out_rem_nz (dv_rem_nz),
    .out_tag    (dv_tag)
  );

  assign dv_keep  = dv_tag[TAG_W-1];
  assign dv_black = dv_tag[TAG_W-2];
  assign dv_white = dv_tag[TAG_W-3];
  assign dv_lower = dv_tag[TAG_W-4];

  // Falling side of the ramp is full scale minus the ceiling
  assign ramp_down = FULL_SCALE - dv_quo - COLOR_W'(dv_rem_nz);

  always_comb begin
    if (dv_black) begin
      colour = '{blue: '0, green: '0, red: '0};
    end else if (dv_white) begin
      colour = '{blue: FULL_SCALE, green: FULL_SCALE, red: FULL_SCALE};
    end else if (dv_lower) begin
      colour = '{blue: ramp_down, green: dv_quo, red: '0};
    end else begin
      colour = '{blue: '0, green: ramp_down, red: dv_quo};
    end
  end

  // Output stage: drop items outside the frame or while zoom is zero
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid && dv_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_col    <= dv_tag[COL_W+ROW_W-1:ROW_W];
      out_row    <= dv_tag[ROW_W-1:0];
      out_colour <= colour;
    end
  end

endmodule

/* hw/rtl/tfc_queue.sv */
// ----------------------------------------------------------------------------
// tfc_queue
// Short first-in first-out queue of classified pixels.
// ----------------------------------------------------------------------------
module tfc_queue #(
  parameter int W     = 34,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Write the tail slot
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/tfc_back.sv */
// ----------------------------------------------------------------------------
// tfc_back
// Replicate each pixel into a zoom-by-zoom block of writes, last one marked.
// ----------------------------------------------------------------------------
module tfc_back #(
  parameter int COL_W = 5,
  parameter int ROW_W = 5,
  parameter int Z_W   = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [Z_W-1:0]                      zoom,
  input  logic                                in_valid,
  output logic                                in_pop,
  input  logic [COL_W-1:0]                    in_col,
  input  logic [ROW_W-1:0]                    in_row,
  input  tfc_pkg::colour_t                    in_colour,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tfc_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                m_tlast
);
  import tfc_pkg::*;

  logic               busy;
  logic [PIX_W-1:0]   base_x;
  logic [PIX_W-1:0]   base_y;
  colour_t            colour;
  logic [Z_W-1:0]     zi;
  logic [Z_W-1:0]     zj;

  logic [Z_W-1:0]       z_last;
  logic                 row_end;
  logic                 last;
  logic                 xfer;
  logic [COL_W+Z_W-1:0] x_prod;
  logic [ROW_W+Z_W-1:0] y_prod;
  logic [PIX_W-1:0]     pixel_x;
  logic [PIX_W-1:0]     pixel_y;

  assign z_last  = zoom - Z_W'(1);
  assign row_end = (zj == z_last);
  assign last    = row_end && (zi == z_last);
  assign xfer    = busy && m_tready;

  // Take the next pixel when empty or when the final write goes out
  assign in_pop = !busy || (xfer && last);

  assign x_prod = (COL_W+Z_W)'(in_col) * (COL_W+Z_W)'(zoom);
  assign y_prod = (ROW_W+Z_W)'(in_row) * (ROW_W+Z_W)'(zoom);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_pop) begin
      busy <= in_valid;
    end
  end

  // Load a pixel or step through the block, rows outer and columns inner
  always_ff @(posedge clk) begin
    if (in_pop) begin
      base_x <= PIX_W'(x_prod);
      base_y <= PIX_W'(y_prod);
      colour <= in_colour;
      zi     <= '0;
      zj     <= '0;
    end else if (xfer) begin
      if (row_end) begin
        zj <= '0;
        zi <= zi + 1'b1;
      end else begin
        zj <= zj + 1'b1;
      end
    end
  end

  assign pixel_x = PIX_W'(base_x + PIX_W'(zj));
  assign pixel_y = PIX_W'(base_y + PIX_W'(zi));

  assign m_tvalid = busy;
  assign m_tlast  = last;
  assign m_tdata  = {colour.blue, colour.green, colour.red, pixel_y, pixel_x};

endmodule

/* hw/rtl/thermal_false_color_pixel_writer_core.sv */
// ----------------------------------------------------------------------------
// thermal_false_color_pixel_writer_core
// Sensor temperature words in, zoomed false-color pixel writes out.
// ----------------------------------------------------------------------------
// Slave stream: one sensor word per transfer; tuser marks the second packet
// half. Master stream: one pixel write per transfer, tlast on the final write
// of the zoom-by-zoom block that one sensor word produces.
// Configuration: write low limit, high limit (whole degrees Celsius) and zoom
// through cfg_we / cfg_index / cfg_data while the block is idle.
// Path from input transfer to the first write of its block: 4 classify stages,
// 8 divider stages, output register, queue, write register. The front takes
// one word per cycle while its output is taken; the back gives one write per
// cycle while the receiver is ready, so a word occupies the back for its whole
// zoom-by-zoom block (one word per cycle at zoom one).
// Words past the frame, or any word while zoom is zero, produce no writes.
// Reset clears the pipeline, the queue and the writer's busy flag and restores
// the limits to 25 and 45 degrees and the zoom to one.
// When the receiver stalls, the current write holds, the four-entry queue
// fills, then the classifier pipeline freezes and tready drops.
// ----------------------------------------------------------------------------
module thermal_false_color_pixel_writer_core #(
  parameter int MAX_ZOOM       = tfc_pkg::MAX_ZOOM_DEF,
  parameter int SENSOR_COLUMNS = tfc_pkg::SENSOR_COLUMNS_DEF,
  parameter int SENSOR_ROWS    = tfc_pkg::SENSOR_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // word_index [9:0], temperature [25:10], zero fill [31:26]
  input  logic [tfc_pkg::IN_DATA_W-1:0]     s_tdata,
  // second_packet [0]
  input  logic                              s_tuser,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // pixel_x [7:0], pixel_y [15:8], red [23:16], green [31:24], blue [39:32]
  output logic [tfc_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_we,
  input  logic [tfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tfc_pkg::CFG_W-1:0]         cfg_data
);
  import tfc_pkg::*;

  localparam int COL_W  = $clog2(SENSOR_COLUMNS);
  localparam int ROW_W  = (SENSOR_ROWS > 1) ? $clog2(SENSOR_ROWS) : 1;
  localparam int Z_W    = $clog2(MAX_ZOOM + 1);
  localparam int ITEM_W = 3 * COLOR_W + ROW_W + COL_W;

  logic signed [LIM_K_W-1:0] lo_limit_k;
  logic signed [LIM_K_W-1:0] hi_limit_k;
  logic [ZOOM_W-1:0]         zoom_factor;
  logic [Z_W-1:0]            zoom;
  logic                      zoom_off;

  logic                      f_valid;
  logic                      f_ready;
  logic [COL_W-1:0]          f_col;
  logic [ROW_W-1:0]          f_row;
  colour_t                   f_colour;

  logic                      q_valid;
  logic                      q_pop;
  logic [ITEM_W-1:0]         q_data;
  logic [COL_W-1:0]          q_col;
  logic [ROW_W-1:0]          q_row;
  colour_t                   q_colour;

  // Configuration writes; limits kept in tenths of a kelvin
  always_ff @(posedge clk) begin
    if (rst) begin
      lo_limit_k  <= LO_K_RESET;
      hi_limit_k  <= HI_K_RESET;
      zoom_factor <= ZOOM_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LOW_LIMIT:  lo_limit_k  <= to_deci_kelvin(cfg_data);
        CFG_HIGH_LIMIT: hi_limit_k  <= to_deci_kelvin(cfg_data);
        CFG_ZOOM:       zoom_factor <= cfg_data[ZOOM_W-1:0];
        default:        ;
      endcase
    end
  end

  // Saturate zoom to the replication limit
  assign zoom     = (zoom_factor > ZOOM_W'(MAX_ZOOM)) ? Z_W'(MAX_ZOOM) : Z_W'(zoom_factor);
  assign zoom_off = (zoom_factor == '0);

  tfc_front #(
    .SENSOR_COLUMNS (SENSOR_COLUMNS),
    .SENSOR_ROWS    (SENSOR_ROWS),
    .COL_W          (COL_W),
    .ROW_W          (ROW_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .second_packet (s_tuser),
    .word_index    (s_tdata[WORD_W-1:0]),
    .temperature   (s_tdata[WORD_W+TEMP_W-1:WORD_W]),
    .lo_limit_k    (lo_limit_k),
    .hi_limit_k    (hi_limit_k),
    .zoom_off      (zoom_off),
    .out_valid     (f_valid),
    .out_ready     (f_ready),
    .out_col       (f_col),
    .out_row       (f_row),
    .out_colour    (f_colour)
  );

  tfc_queue #(
    .W     (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_colour, f_row, f_col}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  assign q_col    = q_data[COL_W-1:0];
  assign q_row    = q_data[COL_W+ROW_W-1:COL_W];
  assign q_colour = colour_t'(q_data[ITEM_W-1:COL_W+ROW_W]);

  tfc_back #(
    .COL_W (COL_W),
    .ROW_W (ROW_W),
    .Z_W   (Z_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .zoom      (zoom),
    .in_valid  (q_valid),
    .in_pop    (q_pop),
    .in_col    (q_col),
    .in_row    (q_row),
    .in_colour (q_colour),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
